// File: rtl/sle_pkg.sv
package sle_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int FOUND_W  = 4;
    localparam int LEN_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int PASS_W   = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SORTED = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_INSERT = 3'd1,
        OP_APPEND = 3'd2,
        OP_DELETE = 3'd3,
        OP_SORT   = 3'd4,
        OP_MATCH  = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic               phase;
        logic [CMP_W-1:0]   pos;
        logic [CMP_W-1:0]   count;
        logic [VAL_W-1:0]   value;
    } t_cell_ctl;

endpackage

// File: rtl/sle_cell.sv
module sle_cell (
    input  logic                      i_clk,
    input  sle_pkg::t_cell_ctl        i_ctl,
    input  logic [sle_pkg::CMP_W-1:0] i_index,
    input  logic [sle_pkg::VAL_W-1:0] i_left,
    input  logic [sle_pkg::VAL_W-1:0] i_right,
    output logic [sle_pkg::VAL_W-1:0] o_data,
    output logic                      o_match
);
    import sle_pkg::*;

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;
    logic             r_match;
    logic             n_match;
    logic [CMP_W-1:0] w_idx_nx;
    logic             w_gt_right;
    logic             w_gt_left;
    logic             w_lower;

    assign w_idx_nx   = i_index + CMP_W'(1);
    assign w_gt_right = $signed(r_data) > $signed(i_right);
    assign w_gt_left  = $signed(i_left) > $signed(r_data);
    assign w_lower    = (i_index[0] == i_ctl.phase);

    always_comb begin
        n_data  = r_data;
        n_match = r_match;
        case (i_ctl.op)
            OP_INSERT: begin
                if (i_index > i_ctl.pos) begin
                    n_data = i_left;
                end else if (i_index == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end
            end
            OP_APPEND: begin
                if (i_index == i_ctl.count) begin
                    n_data = i_ctl.value;
                end
            end
            OP_DELETE: begin
                if (i_index >= i_ctl.pos && w_idx_nx < i_ctl.count) begin
                    n_data = i_right;
                end
            end
            OP_SORT: begin
                if (w_lower) begin
                    if (w_idx_nx < i_ctl.count && w_gt_right) begin
                        n_data = i_right;
                    end
                end else if (i_index != '0 && i_index < i_ctl.count && w_gt_left) begin
                    n_data = i_left;
                end
            end
            OP_MATCH: begin
                n_match = (i_index < i_ctl.count) && (r_data == i_ctl.value);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= n_match;
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

// File: rtl/sequential_list_engine_top.sv
// After accept, o_done follows in the next cycle for insert, delete, read, unused codes and a
// full sorted insert; find goes through ST_FIND, then ST_RESP; sorted insert appends, then
// runs ST_SORT (one odd-even pass per cycle) up to the last pass, then ST_RESP. busy stays
// high until the strobe cycle ends; no new command is accepted while a command is in flight.
// o_done is high for exactly one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the list; entry contents are not cleared.
module sequential_list_engine_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sle_pkg::CMD_W-1:0]          i_cmd,
    input  logic [sle_pkg::POS_W-1:0]          i_position,
    input  logic signed [sle_pkg::VAL_W-1:0]   i_item_value,
    output logic                               o_done,
    output logic [sle_pkg::STAT_W-1:0]         o_status,
    output logic [sle_pkg::FOUND_W-1:0]        o_found_index,
    output logic signed [sle_pkg::VAL_W-1:0]   o_read_value,
    output logic [sle_pkg::LEN_W-1:0]          o_list_length
);
    import sle_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SORT = 4'b0010,
        ST_FIND = 4'b0100,
        ST_RESP = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [PASS_W-1:0]   r_pass;
    logic [PASS_W-1:0]   n_pass;
    logic [STAT_W-1:0]   r_status;
    logic [STAT_W-1:0]   n_status;
    logic [FOUND_W-1:0]  r_found;
    logic [FOUND_W-1:0]  n_found;
    logic [VAL_W-1:0]    r_read;
    logic [VAL_W-1:0]    n_read;

    t_cell_ctl           w_ctl;
    logic [VAL_W-1:0]    w_data [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic [CMP_W-1:0]    w_cnt;
    logic [CMP_W-1:0]    w_pos;

    assign w_cnt = CMP_W'(r_count);
    assign w_pos = CMP_W'(i_position);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        sle_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (CMP_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pass      = r_pass;
        n_status    = r_status;
        n_found     = r_found;
        n_read      = r_read;
        w_ctl.op    = OP_NOP;
        w_ctl.phase = r_pass[0];
        w_ctl.pos   = w_pos;
        w_ctl.count = w_cnt;
        w_ctl.value = i_item_value;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_status = ST_OK;
                    n_found  = '0;
                    n_read   = '0;
                    n_state  = ST_RESP;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (w_cnt >= CMP_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (w_pos > w_cnt) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctl.op = OP_INSERT;
                                n_count  = r_count + CNT_W'(1);
                            end
                        end
                        CMD_SORTED: begin
                            if (w_cnt >= CMP_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.op = OP_APPEND;
                                n_count  = r_count + CNT_W'(1);
                                n_pass   = '0;
                                n_state  = ST_SORT;
                            end
                        end
                        CMD_DELETE: begin
                            if (w_pos >= w_cnt) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctl.op = OP_DELETE;
                                n_count  = r_count - CNT_W'(1);
                            end
                        end
                        CMD_FIND: begin
                            w_ctl.op = OP_MATCH;
                            n_state  = ST_FIND;
                        end
                        CMD_READ: begin
                            if (w_pos >= w_cnt) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_read = w_data[w_pos[IDX_W-1:0]];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SORT: begin
                w_ctl.op = OP_SORT;
                n_pass   = r_pass + PASS_W'(1);
                if (r_pass == PASS_W'(CAPACITY - 1)) begin
                    n_state = ST_RESP;
                end
            end
            ST_FIND: begin
                n_status = ST_NOTFOUND;
                n_found  = '0;
                for (int k = CAPACITY - 1; k >= 0; k--) begin
                    if (w_match[k]) begin
                        n_status = ST_OK;
                        n_found  = FOUND_W'(k);
                    end
                end
                n_state = ST_RESP;
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pass  <= n_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_read   <= n_read;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = (r_state == ST_RESP);
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_read_value  = r_read;
    assign o_list_length = LEN_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy after result strobe");

    a_quick_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd != CMD_SORTED && i_cmd != CMD_FIND) |=> o_done)
        else $error("single-cycle command did not respond");

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

endmodule
